// ----- rtl/core/register_write_packet_framer_assert.svh -----
// Assertion macros shared by the register-write packet framer modules.
`ifndef REGISTER_WRITE_PACKET_FRAMER_ASSERT_SVH
`define REGISTER_WRITE_PACKET_FRAMER_ASSERT_SVH

`ifndef SYNTH

// Check that prop holds in the same cycle as cond.
`define RWPF_ASSERT_IMPLY(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Check that prop holds in the cycle after cond.
`define RWPF_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`else

`define RWPF_ASSERT_IMPLY(lbl, cond, prop, msg)
`define RWPF_ASSERT_NEXT(lbl, cond, prop, msg)

`endif

`endif

// ----- rtl/core/rwpf_pkg.sv -----
// Package: constants, config indexes, queue entry type, serializer states and CRC step.
`default_nettype none

package rwpf_pkg;

    localparam int MAX_VALUES     = 16;
    localparam int WIDE_REG_LIMIT = 4;

    localparam int CNT_W   = $clog2(MAX_VALUES + 1);
    localparam int WORDS_W = $clog2(2 * MAX_VALUES + 1);
    localparam int VC_W    = 5;
    localparam int CMP_W   = (CNT_W > VC_W) ? CNT_W : VC_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] PREAMBLE   = 8'hFB;
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_POLY   = 8'h31;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_ADDRESS = 2'd0,
        CFG_START_REGISTER = 2'd1,
        CFG_VALUE_COUNT    = 2'd2,
        CFG_UNUSED         = 2'd3
    } cfg_index_t;

    // One classified value waiting for the serializer
    typedef struct packed {
        logic [63:0]        value;
        logic               hdr;
        logic               wide;
        logic               pkt_end;
        logic [7:0]         dev_addr;
        logic [7:0]         start_reg;
        logic [WORDS_W-1:0] words;
    } q_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_DATA,
        ST_CRC
    } back_state_t;

    // CRC-8, polynomial 0x31, MSB first, one byte
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rwpf_front.sv -----
// Front end: configuration registers, word-count pass, item classification.
`default_nettype none
`include "register_write_packet_framer_assert.svh"

module rwpf_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [rwpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [63:0]                    s_tdata,
    input  wire logic                           q_ready,
    output logic                                q_push,
    output rwpf_pkg::q_entry_t                  q_entry
);
    import rwpf_pkg::*;

    logic [7:0]        dev_addr_reg;
    logic [7:0]        start_reg_reg;
    logic [VC_W-1:0]   value_count_reg;

    logic [CNT_W-1:0]  values_done_reg, values_done_next;
    logic [7:0]        cur_reg_reg, cur_reg_next;

    logic              calc_busy_reg, calc_busy_next;
    logic              calc_init_reg, calc_init_next;
    logic [7:0]        calc_ptr_reg, calc_ptr_next;
    logic [CNT_W-1:0]  calc_left_reg, calc_left_next;
    logic [WORDS_W-1:0] calc_words_reg, calc_words_next;

    logic [CMP_W-1:0]  vc_ext;
    logic [CNT_W-1:0]  eff_count;
    logic              accept;
    logic [7:0]        item_reg;
    logic              item_wide;
    logic              calc_wide;
    logic [CNT_W-1:0]  done_inc;
    logic              item_last;

    // Clamp the value count into 1..MAX_VALUES
    always_comb begin
        vc_ext = CMP_W'(value_count_reg);
        if (vc_ext == '0) begin
            eff_count = CNT_W'(1);
        end else if (vc_ext > CMP_W'(MAX_VALUES)) begin
            eff_count = CNT_W'(MAX_VALUES);
        end else begin
            eff_count = CNT_W'(vc_ext);
        end
    end

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg    <= 8'd0;
            start_reg_reg   <= 8'd0;
            value_count_reg <= VC_W'(MAX_VALUES);
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEVICE_ADDRESS: dev_addr_reg    <= cfg_wdata;
                CFG_START_REGISTER: start_reg_reg   <= cfg_wdata;
                CFG_VALUE_COUNT:    value_count_reg <= cfg_wdata[VC_W-1:0];
                default: ;
            endcase
        end
    end

    // Word-count pass: walk the packet's registers one value a cycle
    assign calc_wide = {1'b0, calc_ptr_reg} < 9'(WIDE_REG_LIMIT);

    always_comb begin
        calc_busy_next  = calc_busy_reg;
        calc_init_next  = calc_init_reg;
        calc_ptr_next   = calc_ptr_reg;
        calc_left_next  = calc_left_reg;
        calc_words_next = calc_words_reg;
        if (cfg_wr_en) begin
            calc_busy_next = 1'b1;
            calc_init_next = 1'b1;
        end else if (calc_init_reg) begin
            calc_init_next  = 1'b0;
            calc_ptr_next   = start_reg_reg;
            calc_left_next  = eff_count;
            calc_words_next = '0;
        end else if (calc_busy_reg) begin
            calc_words_next = calc_words_reg + (calc_wide ? WORDS_W'(2) : WORDS_W'(1));
            calc_ptr_next   = calc_ptr_reg + (calc_wide ? 8'd2 : 8'd1);
            calc_left_next  = calc_left_reg - CNT_W'(1);
            if (calc_left_reg == CNT_W'(1)) begin
                calc_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calc_busy_reg <= 1'b1;
            calc_init_reg <= 1'b1;
        end else begin
            calc_busy_reg <= calc_busy_next;
            calc_init_reg <= calc_init_next;
        end
        calc_ptr_reg   <= calc_ptr_next;
        calc_left_reg  <= calc_left_next;
        calc_words_reg <= calc_words_next;
    end

    // Classify the accepted item
    assign s_tready  = !calc_busy_reg && q_ready;
    assign accept    = s_tvalid && s_tready;
    assign item_reg  = (values_done_reg == '0) ? start_reg_reg : cur_reg_reg;
    assign item_wide = {1'b0, item_reg} < 9'(WIDE_REG_LIMIT);
    assign done_inc  = values_done_reg + CNT_W'(1);
    assign item_last = done_inc >= eff_count;

    always_comb begin
        values_done_next = values_done_reg;
        cur_reg_next     = cur_reg_reg;
        if (accept) begin
            values_done_next = item_last ? '0 : done_inc;
            cur_reg_next     = item_reg + (item_wide ? 8'd2 : 8'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            values_done_reg <= '0;
            cur_reg_reg     <= 8'd0;
        end else begin
            values_done_reg <= values_done_next;
            cur_reg_reg     <= cur_reg_next;
        end
    end

    // Build the queue entry
    assign q_push = accept;
    always_comb begin
        q_entry.value     = s_tdata;
        q_entry.hdr       = (values_done_reg == '0);
        q_entry.wide      = item_wide;
        q_entry.pkt_end   = item_last;
        q_entry.dev_addr  = dev_addr_reg;
        q_entry.start_reg = start_reg_reg;
        q_entry.words     = calc_words_reg;
    end

    `RWPF_ASSERT_NEXT(a_pkt_end_clears, accept && item_last, values_done_reg == '0, "packet end did not clear value counter")

endmodule

`default_nettype wire

// ----- rtl/core/rwpf_queue.sv -----
// Short queue of classified items between front end and serializer.
`default_nettype none
`include "register_write_packet_framer_assert.svh"

module rwpf_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire rwpf_pkg::q_entry_t push_entry,
    output logic                push_ready,
    input  wire logic           pop,
    output logic                head_valid,
    output rwpf_pkg::q_entry_t  head_entry
);
    import rwpf_pkg::*;

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed items
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `RWPF_ASSERT_IMPLY(a_no_push_full, push, count_reg != QCNT_W'(QUEUE_DEPTH), "push into full queue")
    `RWPF_ASSERT_IMPLY(a_no_pop_empty, pop, count_reg != '0, "pop from empty queue")

endmodule

`default_nettype wire

// ----- rtl/core/rwpf_back.sv -----
// Back end: byte serializer with running CRC-8 and output register.
`default_nettype none
`include "register_write_packet_framer_assert.svh"

module rwpf_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           head_valid,
    input  wire rwpf_pkg::q_entry_t head_entry,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);
    import rwpf_pkg::*;

    back_state_t state_reg, state_next;
    q_entry_t    cur_reg;
    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  crc_reg;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tlast_reg;
    logic        m_tuser_reg;

    logic        out_free;
    logic        emit;
    logic [7:0]  byte_val;
    logic        phase_end;
    logic        item_final;
    logic [2:0]  data_last;
    logic [7:0]  crc_base;
    back_state_t first_state;

    assign out_free    = !m_tvalid_reg || m_tready;
    assign emit        = out_free && (state_reg != ST_IDLE);
    assign data_last   = cur_reg.wide ? 3'd7 : 3'd3;
    assign first_state = head_entry.hdr ? ST_HDR : ST_DATA;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    state_next = first_state;
                end
            end
            ST_HDR: begin
                if (emit && idx_reg == 3'd3) begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                if (emit && idx_reg == data_last) begin
                    if (cur_reg.pkt_end) begin
                        state_next = ST_CRC;
                    end else if (head_valid) begin
                        state_next = first_state;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CRC: begin
                if (emit) begin
                    state_next = head_valid ? first_state : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Byte selection and phase flags
    always_comb begin
        byte_val   = 8'd0;
        phase_end  = 1'b0;
        item_final = 1'b0;
        unique case (state_reg)
            ST_IDLE: ;
            ST_HDR: begin
                case (idx_reg)
                    3'd0:    byte_val = PREAMBLE;
                    3'd1:    byte_val = cur_reg.dev_addr;
                    3'd2:    byte_val = cur_reg.start_reg;
                    default: byte_val = WRITE_FLAG | {1'b0, 7'(cur_reg.words)};
                endcase
                phase_end = idx_reg == 3'd3;
            end
            ST_DATA: begin
                byte_val   = 8'(cur_reg.value >> {idx_reg, 3'b000});
                phase_end  = idx_reg == data_last;
                item_final = phase_end && !cur_reg.pkt_end;
            end
            ST_CRC: begin
                byte_val   = crc_reg;
                phase_end  = 1'b1;
                item_final = 1'b1;
            end
            default: ;
        endcase
    end

    // Pop when idle or when the item's final byte goes out
    assign pop = head_valid && ((state_reg == ST_IDLE) || (emit && item_final));

    always_comb begin
        idx_next = idx_reg;
        if (emit) begin
            idx_next = phase_end ? 3'd0 : idx_reg + 3'd1;
        end
    end

    assign crc_base = (state_reg == ST_HDR && idx_reg == 3'd0) ? CRC_INIT : crc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= 3'd0;
            crc_reg      <= CRC_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (emit) begin
                crc_reg      <= crc_update(crc_base, byte_val);
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Load the working item and the output payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head_entry;
        end
        if (emit) begin
            m_tdata_reg <= byte_val;
            m_tlast_reg <= item_final;
            m_tuser_reg <= state_reg == ST_CRC;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `RWPF_ASSERT_IMPLY(a_crc_ends_item, m_tvalid && m_tuser, m_tlast, "CRC byte not marked last")
    `RWPF_ASSERT_NEXT(a_pop_starts_work, pop, state_reg != ST_IDLE, "popped item not started")

endmodule

`default_nettype wire

// ----- rtl/core/register_write_packet_framer.sv -----
// Top level of the register-write packet framer with CRC-8.
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  s_tdata[63:0] = value_bits
//  m_        out        m_tvalid/m_tready  m_tdata = out_byte, m_tlast, m_tuser
//  cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// The serializer sends one byte per cycle while the output is not stalled: 4 or 8
// data bytes per value, plus 4 header bytes on a packet's first value and 1 CRC
// byte on its last. After reset and after every configuration write, a word-count
// pass of a setup step and then one step per value of the clamped count walks
// the packet's registers; s_tready is low meanwhile. A two-entry queue separates
// the front end from the serializer, so input items keep arriving while the output
// side stalls, until the queue is full.
`default_nettype none

module register_write_packet_framer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [rwpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [63:0]                    s_tdata,   // [63:0] value_bits
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] out_byte
    output logic                                m_tlast,   // last_byte
    output logic                                m_tuser    // [0] packet_end
);
    import rwpf_pkg::*;

    q_entry_t push_entry;
    q_entry_t head_entry;
    logic     push;
    logic     push_ready;
    logic     pop;
    logic     head_valid;

    rwpf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_ready   (push_ready),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    rwpf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    rwpf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire
